FILE: rtl/core/register_region_map_assert.svh
// Assertion macros shared by the register region map RTL.
`ifndef REGISTER_REGION_MAP_ASSERT_SVH
`define REGISTER_REGION_MAP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("register_region_map: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("register_region_map: next-cycle check failed");

`endif

FILE: rtl/core/rrm_pkg.sv
// Types and constants of the register region map.
package rrm_pkg;

  // Request kinds
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Function codes that select a table
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT    = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;

  // Table selects
  localparam logic TBL_HOLDING = 1'b0;
  localparam logic TBL_INPUT   = 1'b1;

  localparam int ADDR_W = 16;
  localparam int OFF_W  = 12;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERLAP   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_COUNT     = 3'd3,
    ST_CODE      = 3'd4,
    ST_FULL      = 3'd5,
    ST_RANGE     = 3'd6
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        function_code;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] register_count;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic             table_select;
    logic [OFF_W-1:0] storage_offset;
  } rsp_t;

  // One region table entry
  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [OFF_W-1:0]  base;
  } region_t;

endpackage

FILE: rtl/core/rrm_if.sv
// Valid/ready channels for requests and responses.
interface rrm_req_if;
  import rrm_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rrm_rsp_if;
  import rrm_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/register_region_map.sv
// Register region map: two address-range tables held in one synchronous RAM.
// Flow: S_IDLE takes a request; code, zero-count and wrap errors go straight to S_DONE,
// others go to S_SCAN, which reads the table one entry per cycle from the RAM and
// compares each word as it comes out; S_DONE loads the output register once it is free
// and waits while rsp holds a beat. A new request is taken only back in S_IDLE.
// Reset (rst, synchronous) clears region counts and used words; RAM is not cleared.
`include "register_region_map_assert.svh"

module register_region_map #(
  parameter int MAX_REGIONS   = 16,
  parameter int STORAGE_WORDS = 4096
) (
  input logic clk,
  input logic rst,
  rrm_req_if.sink   req,
  rrm_rsp_if.source rsp
);
  import rrm_pkg::*;

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AW = $clog2(2 * MAX_REGIONS);
  localparam int WW = $clog2(STORAGE_WORDS + 1);
  localparam int SW = ((WW > ADDR_W) ? WW : ADDR_W) + 1;
  localparam int DEPTH = 2 * MAX_REGIONS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // Request being worked on
  logic              cur_add, cur_add_next;
  logic              cur_tbl, cur_tbl_next;
  logic [ADDR_W-1:0] cur_first, cur_first_next;
  logic [ADDR_W-1:0] cur_last, cur_last_next;
  logic [ADDR_W-1:0] cur_count, cur_count_next;
  logic [CW-1:0]     scan_total, scan_total_next;
  logic [CW-1:0]     rd_idx, rd_idx_next;
  logic              chk_valid, chk_valid_next;
  status_t           res_status, res_status_next;
  logic [OFF_W-1:0]  res_offset, res_offset_next;

  // Per-table counters
  logic [CW-1:0] region_total [2];
  logic [WW-1:0] words_used [2];

  // Output register
  logic out_valid;
  rsp_t out_data;
  logic out_load;

  // Region RAM
  region_t          mem [DEPTH];
  region_t          mem_q;
  logic             mem_re, mem_we;
  logic [AW-1:0]    tbl_base, rd_addr, wr_addr;
  region_t          wr_data;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign tbl_base = cur_tbl ? AW'(MAX_REGIONS) : '0;
  assign rd_addr  = tbl_base + AW'(rd_idx);
  assign wr_addr  = tbl_base + AW'(scan_total);

  // Request decode at acceptance
  logic              dec_hold, dec_input;
  logic [ADDR_W:0]   end_sum;
  logic              dec_wrap;

  always_comb begin
    dec_hold  = (req.payload.function_code == FC_READ_HOLDING) ||
                ((req.payload.req_type == REQ_LOOKUP) &&
                 ((req.payload.function_code == FC_WRITE_SINGLE) ||
                  (req.payload.function_code == FC_WRITE_MULTI)));
    dec_input = (req.payload.function_code == FC_READ_INPUT);
    end_sum   = {1'b0, req.payload.address} + {1'b0, req.payload.register_count};
    dec_wrap  = (req.payload.req_type == REQ_ADD) &&
                (end_sum > {1'b1, {ADDR_W{1'b0}}});
  end

  // Entry compare for the word coming out of the RAM
  logic             hit_add, hit_look, too_long;
  logic [ADDR_W-1:0] span;
  logic [OFF_W-1:0] look_off;
  logic [SW-1:0]    fill_sum;
  logic             store_full;

  always_comb begin
    hit_add    = (cur_first <= mem_q.last) && (cur_last >= mem_q.first);
    hit_look   = (cur_first >= mem_q.first) && (cur_first <= mem_q.last);
    span       = mem_q.last - cur_first;
    too_long   = ({1'b0, span} + 17'd1) < {1'b0, cur_count};
    look_off   = mem_q.base + OFF_W'(cur_first - mem_q.first);
    fill_sum   = SW'(words_used[cur_tbl]) + SW'(cur_count);
    store_full = fill_sum > SW'(STORAGE_WORDS);
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    cur_add_next    = cur_add;
    cur_tbl_next    = cur_tbl;
    cur_first_next  = cur_first;
    cur_last_next   = cur_last;
    cur_count_next  = cur_count;
    scan_total_next = scan_total;
    rd_idx_next     = rd_idx;
    chk_valid_next  = 1'b0;
    res_status_next = res_status;
    res_offset_next = res_offset;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    wr_data.first   = cur_first;
    wr_data.last    = cur_last;
    wr_data.base    = OFF_W'(words_used[cur_tbl]);
    out_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          cur_add_next    = (req.payload.req_type == REQ_ADD);
          cur_first_next  = req.payload.address;
          cur_last_next   = end_sum[ADDR_W-1:0] - 16'd1;
          cur_count_next  = req.payload.register_count;
          rd_idx_next     = '0;
          res_offset_next = '0;
          cur_tbl_next    = dec_input ? TBL_INPUT : TBL_HOLDING;
          scan_total_next = region_total[dec_input];
          priority if (!dec_hold && !dec_input) begin
            res_status_next = ST_CODE;
            state_next      = S_DONE;
          end else if ((req.payload.register_count == '0) || dec_wrap) begin
            res_status_next = ST_RANGE;
            state_next      = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        priority if (chk_valid && cur_add && hit_add) begin
          res_status_next = ST_OVERLAP;
          state_next      = S_DONE;
        end else if (chk_valid && !cur_add && hit_look) begin
          res_status_next = too_long ? ST_COUNT : ST_OK;
          res_offset_next = too_long ? '0 : look_off;
          state_next      = S_DONE;
        end else if (rd_idx != scan_total) begin
          mem_re         = 1'b1;
          rd_idx_next    = rd_idx + 1'b1;
          chk_valid_next = 1'b1;
        end else if (!chk_valid) begin
          // Scan finished without a match
          state_next = S_DONE;
          priority if (!cur_add) begin
            res_status_next = ST_NOT_FOUND;
          end else if ((scan_total == CW'(MAX_REGIONS)) || store_full) begin
            res_status_next = ST_FULL;
          end else begin
            mem_we          = 1'b1;
            res_status_next = ST_OK;
            res_offset_next = OFF_W'(words_used[cur_tbl]);
          end
        end else begin
          // Last entry checked, no match: finish next cycle
        end
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      chk_valid       <= 1'b0;
      out_valid       <= 1'b0;
      region_total[0] <= '0;
      region_total[1] <= '0;
      words_used[0]   <= '0;
      words_used[1]   <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= chk_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        region_total[cur_tbl] <= scan_total + 1'b1;
        words_used[cur_tbl]   <= WW'(fill_sum);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_add    <= cur_add_next;
    cur_tbl    <= cur_tbl_next;
    cur_first  <= cur_first_next;
    cur_last   <= cur_last_next;
    cur_count  <= cur_count_next;
    scan_total <= scan_total_next;
    rd_idx     <= rd_idx_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
    if (out_load) begin
      out_data.status         <= res_status;
      out_data.table_select   <= cur_tbl;
      out_data.storage_offset <= res_offset;
    end
  end

  // Checks
  `RRM_ASSERT_NOW(a_total_bound, 1'b1,
    (region_total[0] <= CW'(MAX_REGIONS)) && (region_total[1] <= CW'(MAX_REGIONS)))
  `RRM_ASSERT_NOW(a_words_bound, 1'b1,
    ({1'b0, words_used[0]} <= (WW+1)'(STORAGE_WORDS)) &&
    ({1'b0, words_used[1]} <= (WW+1)'(STORAGE_WORDS)))
  `RRM_ASSERT_NOW(a_write_only_add, mem_we, (state == S_SCAN) && cur_add && !chk_valid)
  `RRM_ASSERT_NEXT(a_write_bumps_count, mem_we && (cur_tbl == TBL_HOLDING),
    region_total[0] == $past(region_total[0]) + 1'b1)
  `RRM_ASSERT_NOW(a_load_slot_free, out_load, !out_valid || rsp.ready)

endmodule

FILE: sim/tb_register_region_map.sv
// Self-checking testbench for register_region_map: directed and random requests.
`timescale 1ns / 100ps

module tb_register_region_map;
  import rrm_pkg::*;

  localparam int REGION_SLOTS = 16;
  localparam int STORAGE_SIZE = 4096;
  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRESSURE_AT  = 150;
  localparam int PRESSURE_LEN = 400;

  // Tracks both region tables and the responses they should produce
  class region_tracker;
    logic [ADDR_W-1:0] first_addr [2][REGION_SLOTS];
    logic [ADDR_W-1:0] last_addr  [2][REGION_SLOTS];
    logic [OFF_W-1:0]  base_word  [2][REGION_SLOTS];
    int unsigned used_regions [2];
    int unsigned used_words   [2];
    rsp_t pending_rsp [$];
    int errors;
    int responses;

    function new();
      used_regions = '{0, 0};
      used_words   = '{0, 0};
      errors       = 0;
      responses    = 0;
    endfunction

    // Append a region unless it is malformed, overlapping or out of room
    function status_t add_region(int unsigned t, int unsigned lo, int unsigned cnt,
                                 output int unsigned off);
      int unsigned hi;
      int unsigned n;
      off = 0;
      if (cnt == 0 || lo + cnt - 1 > 32'hFFFF) return ST_RANGE;
      hi = lo + cnt - 1;
      n = used_regions[t];
      for (int i = 0; i < n; i++) begin
        if (lo <= last_addr[t][i] && hi >= first_addr[t][i]) return ST_OVERLAP;
      end
      if (n >= REGION_SLOTS) return ST_FULL;
      if (used_words[t] + cnt > STORAGE_SIZE) return ST_FULL;
      off = used_words[t];
      first_addr[t][n] = ADDR_W'(lo);
      last_addr[t][n]  = ADDR_W'(hi);
      base_word[t][n]  = OFF_W'(off);
      used_regions[t]  = n + 1;
      used_words[t]    = used_words[t] + cnt;
      return ST_OK;
    endfunction

    // First region in insertion order that holds the address
    function status_t find_region(int unsigned t, int unsigned addr, int unsigned cnt,
                                  output int unsigned off);
      off = 0;
      if (cnt == 0) return ST_RANGE;
      for (int i = 0; i < used_regions[t]; i++) begin
        if (addr >= first_addr[t][i] && addr <= last_addr[t][i]) begin
          if (last_addr[t][i] - addr + 1 < cnt) return ST_COUNT;
          off = base_word[t][i] + (addr - first_addr[t][i]);
          return ST_OK;
        end
      end
      return ST_NOT_FOUND;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      int unsigned t;
      int unsigned off;
      bit known;
      want.status         = ST_OK;
      want.table_select   = TBL_HOLDING;
      want.storage_offset = '0;
      known = 1'b1;
      t = 0;
      // Table select by function code; adds take only the two read codes
      if (r.function_code == FC_READ_INPUT) t = 1;
      else if (r.function_code == FC_READ_HOLDING) t = 0;
      else if (r.req_type == REQ_LOOKUP &&
               (r.function_code == FC_WRITE_SINGLE || r.function_code == FC_WRITE_MULTI))
        t = 0;
      else known = 1'b0;
      if (!known) begin
        want.status = ST_CODE;
      end else begin
        want.table_select = (t == 1) ? TBL_INPUT : TBL_HOLDING;
        if (r.req_type == REQ_ADD)
          want.status = add_region(t, 32'(r.address), 32'(r.register_count), off);
        else
          want.status = find_region(t, 32'(r.address), 32'(r.register_count), off);
        want.storage_offset = OFF_W'(off);
      end
      pending_rsp = {pending_rsp, want};
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      responses++;
      if (pending_rsp.size() == 0) begin
        $error("response with none pending: status %0d", got.status);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.table_select !== want.table_select) begin
        $error("table_select: expected %0d, actual %0d", want.table_select,
               got.table_select);
        errors++;
      end
      if (got.storage_offset !== want.storage_offset) begin
        $error("storage_offset: expected %0d, actual %0d", want.storage_offset,
               got.storage_offset);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rrm_req_if req_ch ();
  rrm_rsp_if rsp_ch ();

  region_tracker tracker = new();

  register_region_map #(
    .MAX_REGIONS  (REGION_SLOTS),
    .STORAGE_WORDS(STORAGE_SIZE)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #2 clk = ~clk;

  // Mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t mk(logic kind, logic [7:0] code, int unsigned addr,
                              int unsigned cnt);
    req_t r;
    r.req_type       = kind;
    r.function_code  = code;
    r.address        = ADDR_W'(addr);
    r.register_count = ADDR_W'(cnt);
    return r;
  endfunction

  // Region sizes: mostly small so the tables fill, some zero or huge
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(0, 16'hFFFF);
    if (r < 75) return $urandom_range(1, 64);
    return $urandom_range(1, 512);
  endfunction

  function automatic logic [7:0] lookup_code(int unsigned t);
    if (t == 1) return FC_READ_INPUT;
    case ($urandom_range(0, 2))
      0: return FC_READ_HOLDING;
      1: return FC_WRITE_SINGLE;
      default: return FC_WRITE_MULTI;
    endcase
  endfunction

  // Random request: well-formed adds and lookups aimed at live regions, plus noise
  function automatic req_t make_request();
    int unsigned sel;
    int unsigned t;
    int unsigned k;
    int unsigned lo;
    int unsigned room;
    int unsigned cnt;
    sel = $urandom_range(0, 99);
    t = $urandom_range(0, 1);
    if (sel < 8)
      return mk(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
    if (sel < 40) begin
      lo = $urandom_range(0, 16'hFFFF);
      // Land next to or on top of a live region to hit the overlap edges
      if (tracker.used_regions[t] > 0 && $urandom_range(0, 9) < 3) begin
        k = $urandom_range(0, tracker.used_regions[t] - 1);
        if ($urandom_range(0, 1) == 1) lo = tracker.last_addr[t][k] + 1;
        else lo = tracker.first_addr[t][k] - $urandom_range(0, 3);
      end
      return mk(REQ_ADD, (t == 1) ? FC_READ_INPUT : FC_READ_HOLDING, lo, pick_count());
    end
    if (tracker.used_regions[t] > 0 && $urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, tracker.used_regions[t] - 1);
      lo = tracker.first_addr[t][k] +
           $urandom_range(0, tracker.last_addr[t][k] - tracker.first_addr[t][k]);
      room = tracker.last_addr[t][k] - lo + 1;
      if ($urandom_range(0, 9) < 8) cnt = $urandom_range(1, room);
      else cnt = room + $urandom_range(1, 20);
      return mk(REQ_LOOKUP, lookup_code(t), lo, cnt);
    end
    return mk(REQ_LOOKUP, lookup_code(t), $urandom_range(0, 16'hFFFF), $urandom_range(1, 8));
  endfunction

  // Offer one beat after an optional pause and hold it until accepted
  task automatic send_request(input req_t r, input int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(r);
  endtask

  // Directed pass: bad codes, malformed ranges, overlap, storage full, each lookup code
  task automatic run_directed();
    req_t seq [$];
    seq = {seq, mk(REQ_ADD, 8'h00, 0, 1)};
    seq = {seq, mk(REQ_ADD, FC_WRITE_SINGLE, 10, 1)};
    seq = {seq, mk(REQ_LOOKUP, 8'hFF, 16'hFFFF, 16'hFFFF)};
    seq = {seq, mk(REQ_ADD, FC_READ_HOLDING, 100, 0)};
    seq = {seq, mk(REQ_ADD, FC_READ_HOLDING, 16'hFFFF, 2)};
    seq = {seq, mk(REQ_ADD, FC_READ_HOLDING, 16'hFFFF, 1)};
    seq = {seq, mk(REQ_ADD, FC_READ_HOLDING, 0, 16'hFFFF)};
    seq = {seq, mk(REQ_ADD, FC_READ_HOLDING, 0, 16)};
    seq = {seq, mk(REQ_ADD, FC_READ_HOLDING, 8, 4)};
    seq = {seq, mk(REQ_ADD, FC_READ_HOLDING, 15, 1)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_HOLDING, 3, 13)};
    seq = {seq, mk(REQ_LOOKUP, FC_WRITE_SINGLE, 3, 14)};
    seq = {seq, mk(REQ_LOOKUP, FC_WRITE_MULTI, 16'hFFFF, 1)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_HOLDING, 20, 1)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_INPUT, 0, 1)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_HOLDING, 0, 0)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_HOLDING, 16'hFFFF, 16'hFFFF)};
    seq = {seq, mk(REQ_ADD, FC_READ_INPUT, 16'h8000, 4000)};
    seq = {seq, mk(REQ_ADD, FC_READ_INPUT, 0, 97)};
    seq = {seq, mk(REQ_ADD, FC_READ_INPUT, 0, 96)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_INPUT, 95, 1)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_INPUT, 16'h8000 + 3999, 1)};
    seq = {seq, mk(REQ_LOOKUP, FC_READ_INPUT, 16'h8000, 16'hFFFF)};
    foreach (seq[i]) send_request(seq[i], pick_gap());
  endtask

  // Response side: random stalls, calm phases, one long hold-off to back up the input
  initial begin
    int hold;
    int cycles;
    bit pressure_done;
    hold = 0;
    cycles = 0;
    pressure_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (!pressure_done && tracker.responses >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold = PRESSURE_LEN;
      end else if (hold == 0 && (cycles / 500) % 4 != 1) begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  hold = 0;
          [70:92]: hold = $urandom_range(1, 3);
          [93:98]: hold = $urandom_range(4, 12);
          default: hold = $urandom_range(30, 80);
        endcase
      end
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Check each response beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) tracker.check_response(rsp_ch.payload);
  end

  // Watchdog on cycles with no beat on either channel
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int gap;
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Every third stretch of 60 beats goes without pauses
      gap = ((i / 60) % 3 == 2) ? 0 : pick_gap();
      send_request(make_request(), gap);
    end
    req_ch.valid <= 1'b0;
    while (tracker.pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
